// ===== src/rc_snubber_sim_step_macros.svh =====
// ---------------------------------------------------------------------------
// RC snubber step assertion macros
// Shared concurrent assertion forms for the snubber step block.
// ---------------------------------------------------------------------------
`ifndef RC_SNUBBER_SIM_STEP_MACROS_SVH
`define RC_SNUBBER_SIM_STEP_MACROS_SVH

// Check a property on every clock edge outside reset
`define RCSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define RCSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/rcss_pkg.sv =====
// ---------------------------------------------------------------------------
// RC snubber step package
// Widths, register indexes, micro-op codes and the micro-program of the step.
// ---------------------------------------------------------------------------
package rcss_pkg;

  // Data widths
  localparam int DATA_W      = 32;
  localparam int OPD_W       = DATA_W + 1;   // operand with room for unsigned
  localparam int PROD_W      = 2 * OPD_W;
  localparam int ACC_W       = 50;           // x + charge + coupling fits here
  localparam int NCH         = 3;
  localparam int CH_W        = 2;
  localparam int STEP_W      = 3;
  localparam int CFG_IDX_W   = 8;
  localparam int TDATA_IN_W  = 7 * DATA_W;
  localparam int TUSER_IN_W  = 4;
  localparam int TDATA_OUT_W = 6 * DATA_W;

  // Frame modes
  localparam logic MODE_DQ  = 1'b0;
  localparam logic MODE_ABC = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_MODE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_OVER_CAP = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESISTANCE    = 8'd3;

  typedef logic [CH_W-1:0] ch_t;

  localparam ch_t CH_0 = 2'd0;
  localparam ch_t CH_1 = 2'd1;

  // Last micro-op index of each program
  localparam logic [STEP_W-1:0] DQ_LAST  = 3'd6;
  localparam logic [STEP_W-1:0] ABC_LAST = 3'd5;

  typedef enum logic [1:0] {
    A_CUR   = 2'd0,
    A_SPEED = 2'd1,
    A_CAP   = 2'd2
  } a_sel_t;

  typedef enum logic [1:0] {
    B_SOC  = 2'd0,
    B_RES  = 2'd1,
    B_STEP = 2'd2,
    B_DTW  = 2'd3
  } b_sel_t;

  typedef enum logic [1:0] {
    SH16 = 2'd0,
    SH24 = 2'd1,
    SH32 = 2'd2
  } shift_t;

  typedef enum logic [1:0] {
    ACC_SET  = 2'd0,   // acc = product term
    ACC_BASE = 2'd1,   // acc = capacitor voltage + product term
    ACC_ADD  = 2'd2,   // acc = acc + product term
    ACC_SUB  = 2'd3    // acc = acc - product term
  } acc_op_t;

  typedef enum logic [1:0] {
    DST_NONE = 2'd0,
    DST_DTW  = 2'd1,
    DST_CAP  = 2'd2,
    DST_TERM = 2'd3
  } dest_t;

  typedef struct packed {
    a_sel_t  a_sel;
    ch_t     a_ch;
    b_sel_t  b_sel;
    shift_t  shift;
    acc_op_t acc_op;
    dest_t   dest;
    ch_t     ch;
  } uop_t;

  // Sequencer to datapath control
  typedef struct packed {
    uop_t op;
    logic mul_en;
    logic acc_en;
    logic wr_en;
    logic idle;
    logic done;
    logic mode;
  } seq_ctl_t;

  // Micro-program: each op is one multiply then one accumulate
  function automatic uop_t prog_op(input logic mode, input logic [STEP_W-1:0] idx);
    uop_t u;
    ch_t  ch;
    ch       = idx[STEP_W-1:1];
    u.a_sel  = A_CUR;
    u.a_ch   = CH_0;
    u.b_sel  = B_SOC;
    u.shift  = SH24;
    u.acc_op = ACC_BASE;
    u.dest   = DST_NONE;
    u.ch     = CH_0;
    if (mode == MODE_ABC) begin
      // phase n: charge update, then terminal voltage
      u.a_ch   = ch;
      u.ch     = ch;
      u.b_sel  = idx[0] ? B_RES : B_SOC;
      u.shift  = idx[0] ? SH16 : SH24;
      u.dest   = idx[0] ? DST_TERM : DST_CAP;
    end else begin
      case (idx)
        3'd0: begin
          u.a_sel = A_SPEED; u.b_sel = B_STEP; u.shift = SH32;
          u.acc_op = ACC_SET; u.dest = DST_DTW;
        end
        3'd1: begin
          u.a_ch = CH_0; u.ch = CH_0;
        end
        3'd2: begin
          u.a_sel = A_CAP; u.a_ch = CH_1; u.b_sel = B_DTW; u.shift = SH16;
          u.acc_op = ACC_ADD; u.dest = DST_CAP; u.ch = CH_0;
        end
        3'd3: begin
          u.a_ch = CH_1; u.ch = CH_1;
        end
        3'd4: begin
          u.a_sel = A_CAP; u.a_ch = CH_0; u.b_sel = B_DTW; u.shift = SH16;
          u.acc_op = ACC_SUB; u.dest = DST_CAP; u.ch = CH_1;
        end
        3'd5: begin
          u.a_ch = CH_0; u.b_sel = B_RES; u.shift = SH16;
          u.dest = DST_TERM; u.ch = CH_0;
        end
        3'd6: begin
          u.a_ch = CH_1; u.b_sel = B_RES; u.shift = SH16;
          u.dest = DST_TERM; u.ch = CH_1;
        end
        default: begin
          u.dest = DST_NONE;
        end
      endcase
    end
    return u;
  endfunction

endpackage

// ===== src/rcss_mac.sv =====
// ---------------------------------------------------------------------------
// RC snubber step multiply-accumulate unit
// Shared signed multiplier with registered product, shifter, accumulator and
// 32-bit saturation of the running sum.
// ---------------------------------------------------------------------------
module rcss_mac import rcss_pkg::*; (
  input  logic                     clk,
  input  logic                     mul_en,
  input  logic                     acc_en,
  input  shift_t                   shift,
  input  acc_op_t                  acc_op,
  input  logic signed [OPD_W-1:0]  op_a,
  input  logic signed [OPD_W-1:0]  op_b,
  input  logic signed [DATA_W-1:0] base,
  output logic signed [DATA_W-1:0] sat_val
);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [ACC_W-1:0]  shifted;
  logic signed [ACC_W-1:0]  base_ext;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic [ACC_W-DATA_W:0]    top_bits;

  // Register the product and the accumulator
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= op_a * op_b;
    end
    if (acc_en) begin
      acc <= acc_next;
    end
  end

  // Scale the product, rounding toward minus infinity
  always_comb begin
    case (shift)
      SH16:    prod_sh = prod >>> 16;
      SH24:    prod_sh = prod >>> 24;
      SH32:    prod_sh = prod >>> 32;
      default: prod_sh = prod;
    endcase
    shifted  = prod_sh[ACC_W-1:0];
    base_ext = {{(ACC_W-DATA_W){base[DATA_W-1]}}, base};
  end

  // Accumulate
  always_comb begin
    case (acc_op)
      ACC_SET:  acc_next = shifted;
      ACC_BASE: acc_next = base_ext + shifted;
      ACC_ADD:  acc_next = acc + shifted;
      ACC_SUB:  acc_next = acc - shifted;
      default:  acc_next = shifted;
    endcase
  end

  // Clamp to the signed 32-bit range
  always_comb begin
    top_bits = acc_next[ACC_W-1:DATA_W-1];
    if ((&top_bits) || !(|top_bits)) begin
      sat_val = acc_next[DATA_W-1:0];
    end else if (acc_next[ACC_W-1]) begin
      sat_val = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule

// ===== src/rcss_ctrl.sv =====
// ---------------------------------------------------------------------------
// RC snubber step sequencer
// Walks the micro-program for one request (a dq non-conducting request skips
// it), a multiply then an accumulate state per op, then holds until the result register is free.
// ---------------------------------------------------------------------------
module rcss_ctrl import rcss_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           frame_mode,
  input  logic           conducting,
  input  logic [NCH-1:0] phase_mask,
  input  logic           out_free,
  output seq_ctl_t       ctl
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_ACC  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [STEP_W-1:0]   step;
  logic [STEP_W-1:0]   step_next;
  logic [STEP_W-1:0]   last_step;
  logic                mode;
  logic [NCH-1:0]      mask;
  uop_t                op;

  // Hold state, step and the latched request mode and phase mask
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      mode  <= MODE_DQ;
      mask  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (start) begin
        mode <= frame_mode;
        mask <= phase_mask;
      end
    end
  end

  assign last_step = (mode == MODE_ABC) ? ABC_LAST : DQ_LAST;

  // Advance through the program
  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      S_IDLE: begin
        if (start) begin
          step_next  = '0;
          state_next = (frame_mode == MODE_DQ && !conducting) ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_ACC;
      end
      S_ACC: begin
        if (step == last_step) begin
          state_next = S_DONE;
        end else begin
          step_next  = step + 1'b1;
          state_next = S_MUL;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Drive the datapath
  always_comb begin
    op         = prog_op(mode, step);
    ctl.op     = op;
    ctl.mul_en = (state == S_MUL);
    ctl.acc_en = (state == S_ACC);
    ctl.wr_en  = (state == S_ACC) && (mode == MODE_DQ || mask[op.ch]);
    ctl.idle   = (state == S_IDLE);
    ctl.done   = (state == S_DONE);
    ctl.mode   = mode;
  end

endmodule

// ===== src/rc_snubber_sim_step.sv =====
// ---------------------------------------------------------------------------
// RC snubber simulation step
// Top level: configuration registers, capacitor and reported state, operand
// selection, shared multiply-accumulate unit and the result register.
// ---------------------------------------------------------------------------
// One request is one simulation time step; the block takes a request only
// when idle and returns one result per request. All arithmetic runs through a
// single 33x33 signed multiplier with a registered product, and each product
// passes a multiply state, then a shift/accumulate/saturate state. A dq
// conducting step runs 7 products; an abc step runs 6 products (masked
// phases are loaded at once but still sequenced); a dq non-conducting step
// only loads the capacitors. The result register frees the input side, so a
// new request is taken while the last result waits on the output.
// Configuration writes are taken every cycle and belong between requests.
// ---------------------------------------------------------------------------
`include "rc_snubber_sim_step_macros.svh"

module rc_snubber_sim_step import rcss_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DATA_W-1:0]      cfg_data,
  // request stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // s_tdata: current_0, current_1, current_2, volt_in_0, volt_in_1,
  //          volt_in_2, elec_speed (32 bits each, lowest first)
  input  logic [TDATA_IN_W-1:0]  s_tdata,
  // s_tuser: dq_conducting [0], phase_mask [3:1]
  input  logic [TUSER_IN_W-1:0]  s_tuser,
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // m_tdata: term_volt_0, term_volt_1, term_volt_2, cap_volt_0, cap_volt_1,
  //          cap_volt_2 (32 bits each, lowest first)
  output logic [TDATA_OUT_W-1:0] m_tdata
);

  // Configuration registers
  logic                     frame_mode;
  logic [DATA_W-1:0]        step_time;
  logic [DATA_W-1:0]        step_over_cap;
  logic [DATA_W-1:0]        resistance;

  // Step state
  logic signed [DATA_W-1:0] cap_state  [NCH];
  logic signed [DATA_W-1:0] shown_cap  [NCH];
  logic signed [DATA_W-1:0] shown_term [NCH];
  logic signed [DATA_W-1:0] dtw;

  // Latched request operands
  logic signed [DATA_W-1:0] cur_q [NCH];
  logic signed [DATA_W-1:0] speed_q;

  // Unpacked request fields
  logic signed [DATA_W-1:0] cur_in  [NCH];
  logic signed [DATA_W-1:0] vin_in  [NCH];
  logic signed [DATA_W-1:0] speed_in;
  logic                     dq_conducting;
  logic [NCH-1:0]           phase_mask;

  logic                     start;
  logic                     out_free;
  seq_ctl_t                 ctl;
  logic signed [OPD_W-1:0]  op_a;
  logic signed [OPD_W-1:0]  op_b;
  logic signed [DATA_W-1:0] sat_val;

  // Unpack the request
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      cur_in[i] = s_tdata[DATA_W*i +: DATA_W];
      vin_in[i] = s_tdata[DATA_W*(NCH+i) +: DATA_W];
    end
    speed_in      = s_tdata[DATA_W*2*NCH +: DATA_W];
    dq_conducting = s_tuser[0];
    phase_mask    = s_tuser[NCH:1];
  end

  assign start     = s_tvalid && s_tready;
  assign s_tready  = ctl.idle;
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  // Write configuration registers, drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode    <= MODE_DQ;
      step_time     <= '0;
      step_over_cap <= '0;
      resistance    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_MODE:    frame_mode    <= cfg_data[0];
        REG_STEP_TIME:     step_time     <= cfg_data;
        REG_STEP_OVER_CAP: step_over_cap <= cfg_data;
        REG_RESISTANCE:    resistance    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Latch request operands used by the program
  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < NCH; i++) begin
        cur_q[i] <= cur_in[i];
      end
      speed_q <= speed_in;
    end
  end

  rcss_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .frame_mode (frame_mode),
    .conducting (dq_conducting),
    .phase_mask (phase_mask),
    .out_free   (out_free),
    .ctl        (ctl)
  );

  // Select multiplier operands
  always_comb begin
    case (ctl.op.a_sel)
      A_CUR:   op_a = {cur_q[ctl.op.a_ch][DATA_W-1], cur_q[ctl.op.a_ch]};
      A_SPEED: op_a = {speed_q[DATA_W-1], speed_q};
      A_CAP:   op_a = {cap_state[ctl.op.a_ch][DATA_W-1], cap_state[ctl.op.a_ch]};
      default: op_a = '0;
    endcase
    case (ctl.op.b_sel)
      B_SOC:   op_b = {1'b0, step_over_cap};
      B_RES:   op_b = {1'b0, resistance};
      B_STEP:  op_b = {1'b0, step_time};
      B_DTW:   op_b = {dtw[DATA_W-1], dtw};
      default: op_b = '0;
    endcase
  end

  rcss_mac u_mac (
    .clk     (clk),
    .mul_en  (ctl.mul_en),
    .acc_en  (ctl.acc_en),
    .shift   (ctl.op.shift),
    .acc_op  (ctl.op.acc_op),
    .op_a    (op_a),
    .op_b    (op_b),
    .base    (cap_state[ctl.op.ch]),
    .sat_val (sat_val)
  );

  // Load capacitors on request, write back program results
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCH; i++) begin
        cap_state[i]  <= '0;
        shown_cap[i]  <= '0;
        shown_term[i] <= '0;
      end
      dtw <= '0;
    end else if (start) begin
      if (frame_mode == MODE_DQ) begin
        if (!dq_conducting) begin
          cap_state[CH_0] <= vin_in[CH_0];
          cap_state[CH_1] <= vin_in[CH_1];
        end
      end else begin
        for (int i = 0; i < NCH; i++) begin
          if (!phase_mask[i]) begin
            cap_state[i]  <= vin_in[i];
            shown_cap[i]  <= vin_in[i];
            shown_term[i] <= vin_in[i];
          end
        end
      end
    end else if (ctl.wr_en) begin
      case (ctl.op.dest)
        DST_DTW: begin
          dtw <= sat_val;
        end
        DST_CAP: begin
          cap_state[ctl.op.ch] <= sat_val;
          shown_cap[ctl.op.ch] <= sat_val;
        end
        DST_TERM: begin
          shown_term[ctl.op.ch] <= sat_val;
        end
        default: ;
      endcase
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.done && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.done && out_free) begin
      m_tdata <= {shown_cap[2], shown_cap[1], shown_cap[0],
                  shown_term[2], shown_term[1], shown_term[0]};
    end
  end

  // Checks
  `RCSS_ASSERT_ALWAYS(a_reset_idle, rst |=> s_tready && !m_tvalid, "not idle after reset")
  `RCSS_ASSERT(a_busy_after_req, start |=> !s_tready, "request taken while busy")
  `RCSS_ASSERT(a_result_from_done, $rose(m_tvalid) |-> $past(ctl.done), "result without finished step")
  `RCSS_ASSERT(a_dq_ch2_held, ctl.acc_en && ctl.mode == MODE_DQ |=> $stable(cap_state[2]) && $stable(shown_cap[2]) && $stable(shown_term[2]), "channel 2 changed in dq step")
  `RCSS_ASSERT(a_dtw_dq_only, ctl.wr_en && ctl.op.dest == DST_DTW |-> ctl.mode == MODE_DQ, "speed term written in abc step")

endmodule

// ===== bench/tb_top.sv =====
// ---------------------------------------------------------------------------
// RC snubber step testbench
// Drives time-step requests and register writes into the snubber step block,
// predicts every result with a cycle-free model of the capacitor update in
// both frames, and compares each returned result field by field.
// ---------------------------------------------------------------------------
module tb_top;
  import rcss_pkg::*;

  // Handy Q16.16 values
  localparam logic [31:0] Q_ONE     = 32'h0001_0000;
  localparam logic [31:0] Q_MAX     = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN     = 32'h8000_0000;
  localparam logic [31:0] Q_NEG_ONE = 32'hffff_ffff;
  localparam logic [31:0] U_ALL     = 32'hffff_ffff;
  localparam longint      LIM_HI    = 64'sd2147483647;
  localparam longint      LIM_LO    = -64'sd2147483648;

  // One time-step request as sent on the input stream
  typedef struct packed {
    logic             conducting;
    logic [2:0]       mask;
    logic [31:0]      speed;
    logic [2:0][31:0] vin;
    logic [2:0][31:0] cur;
  } step_req_t;

  // One result, laid out as m_tdata: terminal voltages in the low bits
  typedef struct packed {
    logic [2:0][31:0] cap;
    logic [2:0][31:0] term;
  } volt_set_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [DATA_W-1:0]      cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [TDATA_IN_W-1:0]  s_tdata;
  logic [TUSER_IN_W-1:0]  s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [TDATA_OUT_W-1:0] m_tdata;

  // Predicted registers and state
  logic             snub_mode      = MODE_DQ;
  logic [31:0]      snub_dt        = '0;
  logic [31:0]      snub_dt_over_c = '0;
  logic [31:0]      snub_ohms      = '0;
  logic [2:0][31:0] cap_v          = '0;
  logic [2:0][31:0] shown_cap_v    = '0;
  logic [2:0][31:0] shown_term_v   = '0;

  volt_set_t pending_volts[$];
  int        mismatches;
  bit        idle_en;
  int        sink_hold_req;

  rc_snubber_sim_step dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5000000;
    $display("[rc_snubber_sim_step] ERROR");
    $finish;
  end

  // ---- Prediction --------------------------------------------------------

  function automatic longint sx(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint ux(input logic [31:0] v);
    return longint'({32'b0, v});
  endfunction

  // Exact product, then arithmetic shift (floor)
  function automatic longint mul_shift(input longint a, input longint b, input int sh);
    return (a * b) >>> sh;
  endfunction

  function automatic logic [31:0] sat32(input longint v);
    if (v > LIM_HI) return Q_MAX;
    if (v < LIM_LO) return Q_MIN;
    return v[31:0];
  endfunction

  // Publish one channel after its capacitor update
  function automatic void show_channel(input int ch, input logic [31:0] cur);
    shown_cap_v[ch]  = cap_v[ch];
    shown_term_v[ch] = sat32(sx(cap_v[ch]) + mul_shift(sx(cur), ux(snub_ohms), 16));
  endfunction

  // Advance the predicted snubber by one time step and return the result
  function automatic volt_set_t advance_snubber(input step_req_t r);
    volt_set_t out;
    longint    dtw;
    if (snub_mode == MODE_DQ) begin
      if (r.conducting) begin
        dtw = mul_shift(ux(snub_dt), sx(r.speed), 32);
        cap_v[0] = sat32(sx(cap_v[0]) + mul_shift(sx(r.cur[0]), ux(snub_dt_over_c), 24)
                         + mul_shift(dtw, sx(cap_v[1]), 16));
        // y uses the fresh x
        cap_v[1] = sat32(sx(cap_v[1]) + mul_shift(sx(r.cur[1]), ux(snub_dt_over_c), 24)
                         - mul_shift(dtw, sx(cap_v[0]), 16));
        for (int ch = 0; ch < 2; ch++) show_channel(ch, r.cur[ch]);
      end else begin
        // load capacitors, hold what is reported
        cap_v[0] = r.vin[0];
        cap_v[1] = r.vin[1];
      end
    end else begin
      for (int ch = 0; ch < NCH; ch++) begin
        if (r.mask[ch]) begin
          cap_v[ch] = sat32(sx(cap_v[ch])
                            + mul_shift(sx(r.cur[ch]), ux(snub_dt_over_c), 24));
          show_channel(ch, r.cur[ch]);
        end else begin
          cap_v[ch]        = r.vin[ch];
          shown_cap_v[ch]  = r.vin[ch];
          shown_term_v[ch] = r.vin[ch];
        end
      end
    end
    out.cap  = shown_cap_v;
    out.term = shown_term_v;
    return out;
  endfunction

  // ---- Random values -----------------------------------------------------

  function automatic logic [31:0] pick_edge();
    case ($urandom_range(0, 3))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      default: return Q_NEG_ONE;
    endcase
  endfunction

  // Signed Q16.16: extremes, up to 100 volts or amps either way, or anything
  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 7))
      0:       return pick_edge();
      1, 2:    return $urandom_range(0, 200 << 16) - (100 << 16);
      default: return $urandom();
    endcase
  endfunction

  // Unsigned register value: extremes, up to one in Q8.24, or anything
  function automatic logic [31:0] rand_reg();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return U_ALL;
      2, 3:    return $urandom_range(0, 1 << 24);
      default: return $urandom();
    endcase
  endfunction

  // Frame mode word with junk in the upper bits
  function automatic logic [DATA_W-1:0] mode_word(input logic m);
    logic [DATA_W-1:0] w;
    w    = $urandom();
    w[0] = m;
    return w;
  endfunction

  function automatic step_req_t rand_step();
    step_req_t r;
    r.conducting = ($urandom_range(0, 9) < 8);
    r.mask       = $urandom_range(0, 7);
    for (int ch = 0; ch < NCH; ch++) begin
      r.cur[ch] = rand_q16();
      r.vin[ch] = rand_q16();
    end
    r.speed = rand_q16();
    return r;
  endfunction

  function automatic step_req_t make_step(input logic cond, input logic [2:0] mask,
                                          input logic [31:0] c0, c1, c2,
                                          input logic [31:0] v0, v1, v2,
                                          input logic [31:0] spd);
    step_req_t r;
    r.conducting = cond;
    r.mask       = mask;
    r.cur        = {c2, c1, c0};
    r.vin        = {v2, v1, v0};
    r.speed      = spd;
    return r;
  endfunction

  // ---- Drivers -----------------------------------------------------------

  // Offer one request, hold it until taken, record its prediction
  task automatic send_step(input step_req_t r);
    s_tvalid <= 1'b1;
    s_tdata  <= {r.speed, r.vin[2], r.vin[1], r.vin[0], r.cur[2], r.cur[1], r.cur[0]};
    s_tuser  <= {r.mask, r.conducting};
    do @(posedge clk); while (!s_tready);
    pending_volts.push_back(advance_snubber(r));
  endtask

  task automatic pause_requests(input int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (idle_en && $urandom_range(0, 3) == 0) pause_requests($urandom_range(1, 8));
  endtask

  // Drop valid and wait until every result is back
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_volts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAME_MODE:    snub_mode      = val[0];
      REG_STEP_TIME:     snub_dt        = val;
      REG_STEP_OVER_CAP: snub_dt_over_c = val;
      REG_RESISTANCE:    snub_ohms      = val;
      default: ;
    endcase
  endtask

  // Write every register plus one unused index; block must be idle
  task automatic configure(input logic [DATA_W-1:0] mode_w, dt, dt_over_c, ohms);
    settle();
    write_reg(REG_FRAME_MODE, mode_w);
    write_reg(REG_STEP_TIME, dt);
    write_reg(REG_STEP_OVER_CAP, dt_over_c);
    write_reg(REG_RESISTANCE, ohms);
    write_reg($urandom_range(REG_RESISTANCE + 1, 255), $urandom());
    cfg_valid <= 1'b0;
  endtask

  task automatic run_steps(input int n);
    repeat (n) begin
      send_step(rand_step());
      maybe_gap();
    end
  endtask

  // ---- Result side -------------------------------------------------------

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req > 0) begin
        hold_left     = sink_hold_req;
        sink_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    volt_set_t want;
    volt_set_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_volts.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
      end else begin
        want = pending_volts.pop_front();
        for (int ch = 0; ch < NCH; ch++) begin
          if (got.term[ch] !== want.term[ch]) begin
            mismatches++;
            $display("%0t: term_volt_%0d expected %h got %h",
                     $time, ch, want.term[ch], got.term[ch]);
          end
          if (got.cap[ch] !== want.cap[ch]) begin
            mismatches++;
            $display("%0t: cap_volt_%0d expected %h got %h",
                     $time, ch, want.cap[ch], got.cap[ch]);
          end
        end
      end
    end
  end

  // ---- Tests -------------------------------------------------------------

  // dq frame: load, integrate, coupling, saturation, ignored channel 2
  task automatic test_directed_dq();
    configure(32'hffff_fffe, 32'h0010_0000, 32'h0100_0000, Q_ONE);
    send_step(make_step(1'b0, 3'd0, '0, '0, '0, 5 * Q_ONE, -3 * Q_ONE, '0, '0));
    send_step(make_step(1'b1, 3'd0, Q_ONE, 2 * Q_ONE, '0, '0, '0, '0, 100 * Q_ONE));
    send_step(make_step(1'b1, 3'd7, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
    send_step(make_step(1'b1, 3'd5, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
    send_step(make_step(1'b0, 3'd7, Q_NEG_ONE, Q_ONE, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX));
    send_step(make_step(1'b1, 3'd2, '0, '0, Q_MAX, '0, '0, Q_MIN, '0));
    configure(mode_word(MODE_DQ), U_ALL, U_ALL, U_ALL);
    send_step(make_step(1'b1, 3'd0, Q_MAX, Q_MAX, '0, '0, '0, '0, Q_MAX));
    send_step(make_step(1'b1, 3'd0, Q_MIN, Q_MIN, '0, '0, '0, '0, Q_MIN));
    send_step(make_step(1'b0, 3'd0, '0, '0, '0, Q_ONE, Q_NEG_ONE, '0, '0));
    send_step(make_step(1'b1, 3'd6, Q_NEG_ONE, Q_ONE, Q_NEG_ONE, '0, '0, '0, Q_NEG_ONE));
  endtask

  // abc frame: every phase mask, loads, saturation at both ends
  task automatic test_directed_abc();
    configure(32'h8000_0001, $urandom(), 32'h0080_0000, 2 * Q_ONE);
    send_step(make_step(1'b1, 3'd0, Q_ONE, Q_ONE, Q_ONE, 3 * Q_ONE, -5 * Q_ONE, Q_MAX,
                        Q_MAX));
    for (int m = 1; m < 8; m++)
      send_step(make_step(!m[0], m[2:0], Q_ONE, -2 * Q_ONE, Q_ONE >> 1, Q_MIN,
                          7 * Q_ONE, -Q_ONE, $urandom()));
    configure(mode_word(MODE_ABC), '0, U_ALL, U_ALL);
    send_step(make_step(1'b0, 3'd7, Q_MAX, Q_MAX, Q_MAX, '0, '0, '0, '0));
    send_step(make_step(1'b1, 3'd7, Q_MIN, Q_MIN, Q_MIN, '0, '0, '0, '0));
    send_step(make_step(1'b0, 3'd5, Q_NEG_ONE, Q_MAX, Q_ONE, '0, Q_MIN, '0, Q_MIN));
  endtask

  task automatic test_random_dq();
    configure(mode_word(MODE_DQ), '0, '0, '0);
    run_steps(50);
    configure(mode_word(MODE_DQ), U_ALL, U_ALL, U_ALL);
    run_steps(50);
    repeat (5) begin
      configure(mode_word(MODE_DQ), rand_reg(), rand_reg(), rand_reg());
      run_steps(50);
    end
  endtask

  task automatic test_random_abc();
    configure(mode_word(MODE_ABC), U_ALL, '0, '0);
    run_steps(50);
    configure(mode_word(MODE_ABC), '0, U_ALL, U_ALL);
    run_steps(50);
    repeat (5) begin
      configure(mode_word(MODE_ABC), rand_reg(), rand_reg(), rand_reg());
      run_steps(50);
    end
  endtask

  task automatic test_mode_switching();
    repeat (6) begin
      configure(mode_word($urandom_range(0, 1) ? MODE_ABC : MODE_DQ),
                rand_reg(), rand_reg(), rand_reg());
      run_steps(25);
    end
  endtask

  // Receiver holds off long while requests keep coming, then sender waits it out
  task automatic test_backpressure();
    configure(mode_word($urandom_range(0, 1) ? MODE_ABC : MODE_DQ),
              rand_reg(), rand_reg(), rand_reg());
    sink_hold_req = 150;
    repeat (12) send_step(rand_step());
    settle();
    run_steps(8);
  endtask

  // Full rate on both sides
  task automatic test_full_rate();
    idle_en = 1'b0;
    configure(mode_word(MODE_DQ), rand_reg(), rand_reg(), rand_reg());
    run_steps(75);
    configure(mode_word(MODE_ABC), rand_reg(), rand_reg(), rand_reg());
    run_steps(75);
  endtask

  // ---- Sequence ----------------------------------------------------------

  initial begin
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    mismatches    = 0;
    idle_en       = 1'b1;
    sink_hold_req = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_dq();
    test_directed_abc();
    test_random_dq();
    test_random_abc();
    test_mode_switching();
    test_backpressure();
    test_full_rate();

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[rc_snubber_sim_step] OK");
    end else begin
      $display("[rc_snubber_sim_step] ERROR");
    end
    $finish;
  end

endmodule
